[sv/rjp_pkg.sv]
// Shared types and constants for the RTP/JPEG packetizer.
// No dependencies; imported by every module of the block.
package rjp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgSsrc   = 3'd0,
    CfgWidth  = 3'd1,
    CfgHeight = 3'd2,
    CfgPtype  = 3'd3,
    CfgLimit  = 3'd4
  } cfg_idx_e;

  // Part kinds carried with the first byte of a part
  typedef enum logic [1:0] {
    CmdFrame  = 2'd0,
    CmdStart  = 2'd1,
    CmdMiddle = 2'd2,
    CmdEnd    = 2'd3
  } cmd_e;

  localparam int unsigned HdrBytes   = 20;
  localparam int unsigned IdxW       = 5;
  localparam logic [IdxW-1:0] DataIdx = IdxW'(HdrBytes);

  localparam logic [7:0] RtpVerByte = 8'h80;
  localparam logic [7:0] JpegTypeSp = 8'h00;
  localparam logic [7:0] JpegType   = 8'h00;
  localparam logic [7:0] JpegQ      = 8'h01;

  localparam logic [31:0] RstSsrc   = 32'd0;
  localparam logic [10:0] RstWidth  = 11'd480;
  localparam logic [10:0] RstHeight = 11'd272;
  localparam logic [6:0]  RstPtype  = 7'd26;
  localparam logic [15:0] RstLimit  = 16'd1400;

  typedef struct packed {
    logic [31:0] ssrc;
    logic [10:0] width;
    logic [10:0] height;
    logic [6:0]  ptype;
    logic [15:0] limit;
  } cfg_t;

  // Everything the emitter needs to send the beats of one input byte
  typedef struct packed {
    logic        has_hdr;
    logic        eop;
    logic        mark;
    logic [7:0]  data;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [23:0] offset;
    logic [31:0] ssrc;
    logic [6:0]  ptype;
    logic [7:0]  width8;
    logic [7:0]  height8;
  } job_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       sop;
    logic       eop;
    logic       last;
  } beat_t;

endpackage

[sv/rjp_track.sv]
// Part and packet tracking: updates sequence, offset and byte counts per
// accepted input byte and builds the emit job. Depends on rjp_pkg.
module rjp_track (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [1:0]    command_i,
  input  logic          first_of_part_i,
  input  logic [23:0]   part_size_i,
  input  logic [31:0]   timestamp_i,
  input  logic [7:0]    data_byte_i,
  input  rjp_pkg::cfg_t cfg_i,
  output logic          job_we_o,
  output rjp_pkg::job_t job_o
);
  import rjp_pkg::*;

  logic [15:0] seq_q, seq_d;
  logic [23:0] off_q, off_d;
  logic [31:0] ts_q, ts_d;
  logic [23:0] part_q, part_d;
  logic [15:0] pkt_q, pkt_d;
  logic        mk_q, mk_d;

  logic [23:0] part_w, off_w;
  logic [31:0] ts_w;
  logic [15:0] pkt_w, pkt_n, limit;
  logic        mk_w, hdr, final_pkt;

  // Apply first-byte latching, then cut the part into packets
  always_comb begin
    part_w = part_q;
    off_w  = off_q;
    ts_w   = ts_q;
    pkt_w  = pkt_q;
    mk_w   = mk_q;
    if (first_of_part_i) begin
      if (command_i == CmdFrame || command_i == CmdStart) begin
        off_w = '0;
        ts_w  = timestamp_i;
      end
      mk_w   = (command_i == CmdFrame || command_i == CmdEnd);
      part_w = part_size_i;
      pkt_w  = '0;
    end
    limit     = (cfg_i.limit == '0) ? 16'd1 : cfg_i.limit;
    hdr       = (pkt_w == '0);
    final_pkt = (part_w <= {8'd0, limit});
    if (hdr) begin
      pkt_n = final_pkt ? part_w[15:0] : limit;
    end else begin
      pkt_n = pkt_w;
    end

    seq_d  = seq_q;
    off_d  = off_q;
    ts_d   = ts_q;
    part_d = part_q;
    pkt_d  = pkt_q;
    mk_d   = mk_q;
    job_we_o = 1'b0;
    if (in_fire_i) begin
      off_d  = off_w;
      ts_d   = ts_w;
      part_d = part_w;
      pkt_d  = pkt_w;
      mk_d   = mk_w;
      if (part_w != '0) begin
        job_we_o = 1'b1;
        pkt_d  = pkt_n - 16'd1;
        part_d = part_w - 24'd1;
        off_d  = off_w + 24'd1;
        if (hdr) begin
          seq_d = seq_q + 16'd1;
        end
      end
    end

    job_o.has_hdr = hdr;
    job_o.eop     = (pkt_n == 16'd1);
    job_o.mark    = final_pkt && mk_w;
    job_o.data    = data_byte_i;
    job_o.seq     = seq_q;
    job_o.ts      = ts_w;
    job_o.offset  = off_w;
    job_o.ssrc    = cfg_i.ssrc;
    job_o.ptype   = cfg_i.ptype;
    job_o.width8  = cfg_i.width[10:3];
    job_o.height8 = cfg_i.height[10:3];
  end

  // Hold tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= '0;
      off_q  <= '0;
      ts_q   <= '0;
      part_q <= '0;
      pkt_q  <= '0;
      mk_q   <= 1'b0;
    end else begin
      seq_q  <= seq_d;
      off_q  <= off_d;
      ts_q   <= ts_d;
      part_q <= part_d;
      pkt_q  <= pkt_d;
      mk_q   <= mk_d;
    end
  end

  // An open packet never outlives its part
  a_pkt_within_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_q != '0 |-> part_q != '0)
    else $error("packet bytes left without part bytes left");

endmodule

[sv/rjp_emit.sv]
// Beat emitter: holds one job, walks the 20 header bytes (if the job has a
// header) and the data byte into an output register. Depends on rjp_pkg.
module rjp_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_we_i,
  input  rjp_pkg::job_t  job_i,
  output logic           job_free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rjp_pkg::beat_t beat_o
);
  import rjp_pkg::*;

  job_t            job_q;
  logic            job_vld_q, job_vld_d;
  logic [IdxW-1:0] idx_q, idx_d;
  beat_t           out_q, out_d;
  logic            out_vld_q, out_vld_d;

  logic            out_load, last_beat;
  logic [7:0]      hbyte;

  // Pick the header byte at the current index
  always_comb begin
    case (idx_q)
      5'd0:    hbyte = RtpVerByte;
      5'd1:    hbyte = {job_q.mark, job_q.ptype};
      5'd2:    hbyte = job_q.seq[15:8];
      5'd3:    hbyte = job_q.seq[7:0];
      5'd4:    hbyte = job_q.ts[31:24];
      5'd5:    hbyte = job_q.ts[23:16];
      5'd6:    hbyte = job_q.ts[15:8];
      5'd7:    hbyte = job_q.ts[7:0];
      5'd8:    hbyte = job_q.ssrc[31:24];
      5'd9:    hbyte = job_q.ssrc[23:16];
      5'd10:   hbyte = job_q.ssrc[15:8];
      5'd11:   hbyte = job_q.ssrc[7:0];
      5'd12:   hbyte = JpegTypeSp;
      5'd13:   hbyte = job_q.offset[23:16];
      5'd14:   hbyte = job_q.offset[15:8];
      5'd15:   hbyte = job_q.offset[7:0];
      5'd16:   hbyte = JpegType;
      5'd17:   hbyte = JpegQ;
      5'd18:   hbyte = job_q.width8;
      5'd19:   hbyte = job_q.height8;
      default: hbyte = job_q.data;
    endcase
  end

  // Advance through the job as the output register frees up
  always_comb begin
    last_beat  = !job_q.has_hdr || (idx_q == DataIdx);
    out_load   = job_vld_q && (!out_vld_q || out_ready_i);
    job_free_o = !job_vld_q || (out_load && last_beat);

    out_d.pbyte = last_beat ? job_q.data : hbyte;
    out_d.sop   = job_q.has_hdr && (idx_q == '0);
    out_d.eop   = last_beat && job_q.eop;
    out_d.last  = last_beat;

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end

    if (job_we_i) begin
      job_vld_d = 1'b1;
      idx_d     = '0;
    end else if (job_free_o) begin
      job_vld_d = 1'b0;
      idx_d     = '0;
    end else begin
      job_vld_d = job_vld_q;
      idx_d     = out_load ? idx_q + 5'd1 : idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: load job on write, beat on output load
  always_ff @(posedge clk_i) begin
    if (job_we_i) begin
      job_q <= job_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign beat_o      = out_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q |-> idx_q <= DataIdx)
    else $error("beat index past data byte");

  a_plain_job_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q && !job_q.has_hdr |-> idx_q == '0)
    else $error("data-only job walked headers");

  a_sop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.sop |-> !out_q.eop && !out_q.last)
    else $error("start beat also flagged end or last");

endmodule

[sv/rtp_jpeg_packetizer_core.sv]
// RTP/JPEG packetizer top level: configuration registers, tracker and
// beat emitter. Depends on rjp_pkg, rjp_track and rjp_emit.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  command, first_of_part, part_size,
//                                              timestamp, data_byte
//   out      source     out_valid_o/out_ready_i packet_byte, start_of_packet,
//                                              end_of_packet, last_of_run
//   cfg      sink       cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A data byte inside an open packet is sent as a single beat; a byte that
// opens a packet is sent as the 20 header beats and then the data beat, one
// beat per cycle while the output is not stalled.
// Reset clears all tracking state and loads the default configuration.
// A stall on the output holds the emitter and, once its job is pending,
// drops in_ready_o.
module rtp_jpeg_packetizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic        first_of_part_i,
  input  logic [23:0] part_size_i,
  input  logic [31:0] timestamp_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  packet_byte_o,
  output logic        start_of_packet_o,
  output logic        end_of_packet_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import rjp_pkg::*;

  cfg_t  cfg_q;
  job_t  job;
  beat_t beat;
  logic  job_we, job_free, in_fire;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ssrc   <= RstSsrc;
      cfg_q.width  <= RstWidth;
      cfg_q.height <= RstHeight;
      cfg_q.ptype  <= RstPtype;
      cfg_q.limit  <= RstLimit;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSsrc:   cfg_q.ssrc   <= cfg_wdata_i;
        CfgWidth:  cfg_q.width  <= cfg_wdata_i[10:0];
        CfgHeight: cfg_q.height <= cfg_wdata_i[10:0];
        CfgPtype:  cfg_q.ptype  <= cfg_wdata_i[6:0];
        CfgLimit:  cfg_q.limit  <= cfg_wdata_i[15:0];
        default:   cfg_q        <= cfg_q;
      endcase
    end
  end

  assign in_ready_o = job_free;
  assign in_fire    = in_valid_i && job_free;

  rjp_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_fire_i       (in_fire),
    .command_i       (command_i),
    .first_of_part_i (first_of_part_i),
    .part_size_i     (part_size_i),
    .timestamp_i     (timestamp_i),
    .data_byte_i     (data_byte_i),
    .cfg_i           (cfg_q),
    .job_we_o        (job_we),
    .job_o           (job)
  );

  rjp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_we_i    (job_we),
    .job_i       (job),
    .job_free_o  (job_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .beat_o      (beat)
  );

  assign packet_byte_o     = beat.pbyte;
  assign start_of_packet_o = beat.sop;
  assign end_of_packet_o   = beat.eop;
  assign last_of_run_o     = beat.last;

endmodule
